// ===== src/scanline_transfer_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Scanline transfer sequencer assertion macros
// Concurrent checks clocked on the rising edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define SCANLINE_TRANSFER_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define STSEQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STSEQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stseq_pkg.sv =====
// ----------------------------------------------------------------------------
// Scanline transfer sequencer package
// Types, register indexes, source codes and widths shared by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package stseq_pkg;

    localparam int LINE_BITS = 11;
    localparam int VLINE_W   = 11;
    localparam int COUNT_W   = 10;
    localparam int WIDE_W    = (LINE_BITS + 1 > VLINE_W) ? LINE_BITS + 1 : VLINE_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_V_FRONT_PORCH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V_SYNC_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V_BACK_PORCH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V_TOTAL_LINES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_V_ACTIVE_LINES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WORD_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BYTE_TRANSFER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_RENDER     = 3'd7;

    localparam logic [2:0] SRC_VSYNC      = 3'd0;
    localparam logic [2:0] SRC_BLANK_LIST = 3'd1;
    localparam logic [2:0] SRC_PREAMBLE   = 3'd2;
    localparam logic [2:0] SRC_LINE       = 3'd3;
    localparam logic [2:0] SRC_BLANK_LINE = 3'd4;

    localparam logic [COUNT_W-1:0] BLANK_LIST_LEN = 10'd7;
    localparam logic [COUNT_W-1:0] PREAMBLE_LEN   = 10'd9;

    localparam logic [LINE_BITS-1:0] SCANLINE_RESET = LINE_BITS'(2);

    typedef struct packed {
        logic [7:0]         v_front_porch;
        logic [5:0]         v_sync_width;
        logic [7:0]         v_back_porch;
        logic [VLINE_W-1:0] v_total_lines;
        logic [VLINE_W-1:0] v_active_lines;
        logic [COUNT_W-1:0] line_word_count;
        logic               use_byte_transfer;
        logic               manual_render;
    } cfg_t;

    typedef struct packed {
        logic [LINE_BITS-1:0] scanline;
        logic                 pong_turn;
        logic                 preamble_posted;
    } state_t;

    typedef struct packed {
        logic accessor_installed;
        logic line_present;
        logic next_line_present;
        logic mode_change_pending;
    } in_item_t;

    typedef struct packed {
        logic               channel;
        logic               byte_size;
        logic [2:0]         source;
        logic [COUNT_W-1:0] xfer_len;
        logic [VLINE_W-1:0] line_index;
        logic               fetch_rendered;
        logic               render_next;
        logic [VLINE_W-1:0] next_index;
        logic               apply_mode_change;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/scanline_transfer_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Scanline transfer sequencer core
// Result: registered through the input register, then the result register.
// Throughput: one event per cycle while the output is not stalled, set by the combinational state update in stseq_step.
// Reset: synchronous, clears pipeline valids, scanline to 2, flags and registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scanline_transfer_sequencer_core_macros.svh"

module scanline_transfer_sequencer_core (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire  stseq_pkg::in_item_t              s_data,
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output stseq_pkg::out_item_t                   m_data,
    input  wire                                    cfg_we,
    input  wire  [stseq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [stseq_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    stseq_pkg::cfg_t      cfg_reg;
    stseq_pkg::state_t    state_reg;
    stseq_pkg::state_t    state_next;
    stseq_pkg::in_item_t  in_data_reg;
    stseq_pkg::out_item_t result_next;
    stseq_pkg::out_item_t out_data_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    stseq_step u_step (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .item        (in_data_reg),
        .result_next (result_next),
        .state_next  (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
            state_reg.scanline          <= stseq_pkg::SCANLINE_RESET;
            state_reg.pong_turn         <= 1'b0;
            state_reg.preamble_posted   <= 1'b0;
            cfg_reg.v_front_porch       <= 8'd10;
            cfg_reg.v_sync_width        <= 6'd2;
            cfg_reg.v_back_porch        <= 8'd33;
            cfg_reg.v_total_lines       <= 11'd525;
            cfg_reg.v_active_lines      <= 11'd480;
            cfg_reg.line_word_count     <= 10'd160;
            cfg_reg.use_byte_transfer   <= 1'b0;
            cfg_reg.manual_render       <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_index)
                    stseq_pkg::REG_V_FRONT_PORCH:     cfg_reg.v_front_porch <= cfg_wdata[7:0];
                    stseq_pkg::REG_V_SYNC_WIDTH:      cfg_reg.v_sync_width <= cfg_wdata[5:0];
                    stseq_pkg::REG_V_BACK_PORCH:      cfg_reg.v_back_porch <= cfg_wdata[7:0];
                    stseq_pkg::REG_V_TOTAL_LINES:     cfg_reg.v_total_lines <= cfg_wdata[10:0];
                    stseq_pkg::REG_V_ACTIVE_LINES:    cfg_reg.v_active_lines <= cfg_wdata[10:0];
                    stseq_pkg::REG_LINE_WORD_COUNT:   cfg_reg.line_word_count <= cfg_wdata[9:0];
                    stseq_pkg::REG_USE_BYTE_TRANSFER: cfg_reg.use_byte_transfer <= cfg_wdata[0];
                    stseq_pkg::REG_MANUAL_RENDER:     cfg_reg.manual_render <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    `STSEQ_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, m_valid,
        "result lost on advance")
    `STSEQ_ASSERT_NEXT(a_channel_toggles, aclk, aresetn, advance,
        state_reg.pong_turn != $past(state_reg.pong_turn), "channel did not alternate")
    `STSEQ_ASSERT_NEXT(a_preamble_sets_flag, aclk, aresetn,
        advance && result_next.source == stseq_pkg::SRC_PREAMBLE,
        state_reg.preamble_posted, "preamble flag not set")
    `STSEQ_ASSERT_SAME(a_blank_fields_clear, aclk, aresetn,
        m_valid && (m_data.source == stseq_pkg::SRC_VSYNC
            || m_data.source == stseq_pkg::SRC_BLANK_LIST
            || m_data.source == stseq_pkg::SRC_PREAMBLE),
        m_data.line_index == '0 && m_data.next_index == '0
            && !m_data.fetch_rendered && !m_data.render_next,
        "line fields set outside active line")

endmodule

`default_nettype wire

// ===== src/stseq_step.sv =====
// ----------------------------------------------------------------------------
// Scanline transfer sequencer step logic
// Decodes one transfer-complete event against the vertical timing and
// produces the reload command together with the next sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none

module stseq_step (
    input  wire stseq_pkg::cfg_t       cfg,
    input  wire stseq_pkg::state_t     state,
    input  wire stseq_pkg::in_item_t   item,
    output stseq_pkg::out_item_t result_next,
    output stseq_pkg::state_t    state_next
);

    logic [stseq_pkg::WIDE_W-1:0]    scan_w;
    logic [stseq_pkg::WIDE_W-1:0]    sync_start;
    logic [stseq_pkg::WIDE_W-1:0]    sync_end;
    logic [stseq_pkg::WIDE_W-1:0]    blank_end;
    logic [stseq_pkg::WIDE_W-1:0]    scan_inc;
    logic [stseq_pkg::WIDE_W-1:0]    nidx_inc;
    logic [stseq_pkg::LINE_BITS-1:0] lead_lines;
    logic [stseq_pkg::LINE_BITS-1:0] idx;
    logic                            line_ok;
    logic                            posted_next;

    assign scan_w     = stseq_pkg::WIDE_W'(state.scanline);
    assign sync_start = stseq_pkg::WIDE_W'(cfg.v_front_porch);
    assign sync_end   = sync_start + stseq_pkg::WIDE_W'(cfg.v_sync_width);
    assign blank_end  = sync_end + stseq_pkg::WIDE_W'(cfg.v_back_porch);
    assign scan_inc   = scan_w + stseq_pkg::WIDE_W'(1);

    assign lead_lines = stseq_pkg::LINE_BITS'(cfg.v_total_lines)
                      - stseq_pkg::LINE_BITS'(cfg.v_active_lines);
    assign idx        = state.scanline - lead_lines;
    assign nidx_inc   = stseq_pkg::WIDE_W'(idx) + stseq_pkg::WIDE_W'(1);
    assign line_ok    = item.accessor_installed && item.line_present;

    always_comb begin
        result_next                   = '0;
        result_next.channel           = state.pong_turn;
        result_next.byte_size         = state.preamble_posted && cfg.use_byte_transfer;
        posted_next                   = state.preamble_posted;

        if (scan_w >= sync_start && scan_w < sync_end) begin
            result_next.source            = stseq_pkg::SRC_VSYNC;
            result_next.xfer_len          = stseq_pkg::BLANK_LIST_LEN;
            result_next.apply_mode_change = item.mode_change_pending;
        end else if (scan_w < blank_end) begin
            result_next.source         = stseq_pkg::SRC_BLANK_LIST;
            result_next.xfer_len       = stseq_pkg::BLANK_LIST_LEN;
        end else if (!state.preamble_posted) begin
            result_next.source         = stseq_pkg::SRC_PREAMBLE;
            result_next.xfer_len       = stseq_pkg::PREAMBLE_LEN;
            posted_next                = 1'b1;
        end else begin
            result_next.source         = line_ok ? stseq_pkg::SRC_LINE
                                                 : stseq_pkg::SRC_BLANK_LINE;
            result_next.xfer_len       = cfg.line_word_count;
            result_next.line_index     = stseq_pkg::VLINE_W'(idx);
            result_next.fetch_rendered = line_ok && cfg.manual_render;
            result_next.render_next    = cfg.manual_render && item.accessor_installed
                                      && item.next_line_present;
            if (nidx_inc >= stseq_pkg::WIDE_W'(cfg.v_active_lines)) begin
                result_next.next_index = '0;
            end else begin
                result_next.next_index = stseq_pkg::VLINE_W'(nidx_inc);
            end
            posted_next                = 1'b0;
        end
    end

    always_comb begin
        state_next.pong_turn       = !state.pong_turn;
        state_next.preamble_posted = posted_next;
        state_next.scanline        = state.scanline;
        if (!posted_next) begin
            if (scan_inc >= stseq_pkg::WIDE_W'(cfg.v_total_lines)) begin
                state_next.scanline = '0;
            end else begin
                state_next.scanline = stseq_pkg::LINE_BITS'(scan_inc);
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/scanline_transfer_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// Scanline transfer sequencer checker
// Follows the register writes and every accepted event, predicts the reload
// each event calls for, and compares every result field by field, in order.
// ----------------------------------------------------------------------------
module scanline_transfer_sequencer_checker (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    input  wire                                s_ready,
    input  stseq_pkg::in_item_t                s_data,
    input  wire                                m_valid,
    input  wire                                m_ready,
    input  stseq_pkg::out_item_t               m_data,
    input  wire                                cfg_we,
    input  wire [stseq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [stseq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 compared,
    output int                                 line_results,
    output int                                 sync_results
);
    timeunit 1ns;
    timeprecision 1ps;

    stseq_pkg::cfg_t      timing_regs;
    stseq_pkg::state_t    frame_pos;
    stseq_pkg::out_item_t reload_plan_q[$];
    int                   bad;
    int                   seen;
    int                   lines;
    int                   syncs;

    function automatic stseq_pkg::out_item_t plan_reload(input stseq_pkg::in_item_t ev);
        stseq_pkg::out_item_t            r;
        logic [stseq_pkg::LINE_BITS-1:0] s;
        logic [stseq_pkg::LINE_BITS-1:0] idx;
        int                              sync_end;
        int                              blank_end;
        int                              nidx;
        int                              n;
        r = '0;
        s = frame_pos.scanline;
        sync_end = int'(timing_regs.v_front_porch) + int'(timing_regs.v_sync_width);
        blank_end = sync_end + int'(timing_regs.v_back_porch);
        r.channel = frame_pos.pong_turn;
        r.byte_size = frame_pos.preamble_posted & timing_regs.use_byte_transfer;
        frame_pos.pong_turn = ~frame_pos.pong_turn;
        if (int'(s) >= int'(timing_regs.v_front_porch) && int'(s) < sync_end) begin
            r.source = stseq_pkg::SRC_VSYNC;
            r.xfer_len = stseq_pkg::BLANK_LIST_LEN;
            r.apply_mode_change = ev.mode_change_pending;
        end else if (int'(s) < blank_end) begin
            r.source = stseq_pkg::SRC_BLANK_LIST;
            r.xfer_len = stseq_pkg::BLANK_LIST_LEN;
        end else if (!frame_pos.preamble_posted) begin
            r.source = stseq_pkg::SRC_PREAMBLE;
            r.xfer_len = stseq_pkg::PREAMBLE_LEN;
            frame_pos.preamble_posted = 1'b1;
        end else begin
            idx = s - stseq_pkg::LINE_BITS'(timing_regs.v_total_lines
                                            - timing_regs.v_active_lines);
            r.line_index = stseq_pkg::VLINE_W'(idx);
            r.source = (ev.accessor_installed && ev.line_present) ? stseq_pkg::SRC_LINE
                                                                  : stseq_pkg::SRC_BLANK_LINE;
            r.fetch_rendered = ev.accessor_installed & ev.line_present
                               & timing_regs.manual_render;
            r.xfer_len = timing_regs.line_word_count;
            nidx = int'(idx) + 1;
            r.next_index = (nidx >= int'(timing_regs.v_active_lines)) ? '0
                                                                      : stseq_pkg::VLINE_W'(nidx);
            r.render_next = timing_regs.manual_render & ev.accessor_installed
                            & ev.next_line_present;
            frame_pos.preamble_posted = 1'b0;
        end
        if (!frame_pos.preamble_posted) begin
            n = int'(s) + 1;
            frame_pos.scanline = (n >= int'(timing_regs.v_total_lines))
                               ? '0 : stseq_pkg::LINE_BITS'(n);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            bad++;
        end
    endtask

    always @(posedge aclk) begin
        stseq_pkg::out_item_t want;
        if (!aresetn) begin
            timing_regs.v_front_porch = 8'd10;
            timing_regs.v_sync_width = 6'd2;
            timing_regs.v_back_porch = 8'd33;
            timing_regs.v_total_lines = 11'd525;
            timing_regs.v_active_lines = 11'd480;
            timing_regs.line_word_count = 10'd160;
            timing_regs.use_byte_transfer = 1'b0;
            timing_regs.manual_render = 1'b0;
            frame_pos.scanline = stseq_pkg::SCANLINE_RESET;
            frame_pos.pong_turn = 1'b0;
            frame_pos.preamble_posted = 1'b0;
            reload_plan_q.delete();
            bad = 0;
            seen = 0;
            lines = 0;
            syncs = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    stseq_pkg::REG_V_FRONT_PORCH:
                        timing_regs.v_front_porch = cfg_wdata[7:0];
                    stseq_pkg::REG_V_SYNC_WIDTH:
                        timing_regs.v_sync_width = cfg_wdata[5:0];
                    stseq_pkg::REG_V_BACK_PORCH:
                        timing_regs.v_back_porch = cfg_wdata[7:0];
                    stseq_pkg::REG_V_TOTAL_LINES:
                        timing_regs.v_total_lines = cfg_wdata[10:0];
                    stseq_pkg::REG_V_ACTIVE_LINES:
                        timing_regs.v_active_lines = cfg_wdata[10:0];
                    stseq_pkg::REG_LINE_WORD_COUNT:
                        timing_regs.line_word_count = cfg_wdata[9:0];
                    stseq_pkg::REG_USE_BYTE_TRANSFER:
                        timing_regs.use_byte_transfer = cfg_wdata[0];
                    stseq_pkg::REG_MANUAL_RENDER:
                        timing_regs.manual_render = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                reload_plan_q.push_back(plan_reload(s_data));
            end
            if (m_valid && m_ready) begin
                if (reload_plan_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_data);
                    bad++;
                end else begin
                    want = reload_plan_q.pop_front();
                    check_field("channel", want.channel, m_data.channel);
                    check_field("byte_size", want.byte_size, m_data.byte_size);
                    check_field("source", want.source, m_data.source);
                    check_field("xfer_len", want.xfer_len, m_data.xfer_len);
                    check_field("line_index", want.line_index, m_data.line_index);
                    check_field("fetch_rendered", want.fetch_rendered, m_data.fetch_rendered);
                    check_field("render_next", want.render_next, m_data.render_next);
                    check_field("next_index", want.next_index, m_data.next_index);
                    check_field("apply_mode_change", want.apply_mode_change,
                                m_data.apply_mode_change);
                    seen++;
                    if (want.source == stseq_pkg::SRC_LINE
                        || want.source == stseq_pkg::SRC_BLANK_LINE) begin
                        lines++;
                    end
                    if (want.source == stseq_pkg::SRC_VSYNC) begin
                        syncs++;
                    end
                end
            end
        end
        mismatches <= bad;
        outstanding <= reload_plan_q.size();
        compared <= seen;
        line_results <= lines;
        sync_results <= syncs;
    end

endmodule

// ===== tb/tb_scanline_transfer_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Scanline transfer sequencer testbench
// Drives transfer-complete events through a directed frame walk and a series
// of fixed and random timing settings, with random stalls on both channels, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_scanline_transfer_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    stseq_pkg::in_item_t              s_data = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    stseq_pkg::out_item_t             m_data;
    logic                             cfg_we = 1'b0;
    logic [stseq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [stseq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int compared;
    int line_results;
    int sync_results;
    int gap_pct = 0;
    int stall_pct = 0;
    int events_sent = 0;
    int settings_used = 1;

    always #5 aclk = ~aclk;

    scanline_transfer_sequencer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    scanline_transfer_sequencer_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .compared     (compared),
        .line_results (line_results),
        .sync_results (sync_results)
    );

    function automatic stseq_pkg::cfg_t make_timing(input int fp, input int sw, input int bp,
                                                    input int total, input int active,
                                                    input int words, input int byte_mode,
                                                    input int render_mode);
        stseq_pkg::cfg_t c;
        c.v_front_porch = 8'(fp);
        c.v_sync_width = 6'(sw);
        c.v_back_porch = 8'(bp);
        c.v_total_lines = stseq_pkg::VLINE_W'(total);
        c.v_active_lines = stseq_pkg::VLINE_W'(active);
        c.line_word_count = stseq_pkg::COUNT_W'(words);
        c.use_byte_transfer = 1'(byte_mode);
        c.manual_render = 1'(render_mode);
        return c;
    endfunction

    function automatic stseq_pkg::in_item_t random_event();
        stseq_pkg::in_item_t ev;
        ev.accessor_installed = ($urandom_range(99) < 80);
        ev.line_present = ($urandom_range(99) < 75);
        ev.next_line_present = 1'($urandom);
        ev.mode_change_pending = 1'($urandom);
        return ev;
    endfunction

    function automatic int idle_choice();
        case ($urandom_range(2))
            0: return 0;
            1: return 8;
            default: return 25;
        endcase
    endfunction

    task automatic write_reg(input logic [stseq_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= stseq_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
    endtask

    task automatic apply_settings(input stseq_pkg::cfg_t c);
        write_reg(stseq_pkg::REG_V_FRONT_PORCH, c.v_front_porch);
        write_reg(stseq_pkg::REG_V_SYNC_WIDTH, c.v_sync_width);
        write_reg(stseq_pkg::REG_V_BACK_PORCH, c.v_back_porch);
        write_reg(stseq_pkg::REG_V_TOTAL_LINES, c.v_total_lines);
        write_reg(stseq_pkg::REG_V_ACTIVE_LINES, c.v_active_lines);
        write_reg(stseq_pkg::REG_LINE_WORD_COUNT, c.line_word_count);
        write_reg(stseq_pkg::REG_USE_BYTE_TRANSFER, c.use_byte_transfer);
        write_reg(stseq_pkg::REG_MANUAL_RENDER, c.manual_render);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_event(input stseq_pkg::in_item_t ev);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= ev;
        do @(posedge aclk); while (!s_ready);
        events_sent++;
    endtask

    // hold until every expected transfer has come back, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : sink_pacing
        @(posedge aclk);
        forever begin
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    initial begin : stimulus
        stseq_pkg::cfg_t timing;
        int              n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        stall_pct = 20;
        send_event(stseq_pkg::in_item_t'(4'b0000));
        send_event(stseq_pkg::in_item_t'(4'b1111));
        drain();
        // short frame: wrap, underflowed line index, next index wrap, renderer requests
        apply_settings(make_timing(1, 1, 1, 8, 4, 1023, 1, 1));
        for (int k = 0; k < 22; k++) begin
            send_event(stseq_pkg::in_item_t'(4'(k)));
        end

        for (int p = 0; p < 16; p++) begin
            case (p)
                0: timing = make_timing(255, 63, 255, 2047, 2047, 1023, 1, 1);
                1: timing = make_timing(0, 1, 0, 2047, 2047, 1023, 1, 0);
                2: timing = make_timing(0, 1, 0, 2, 1, 1, 0, 1);
                3: timing = make_timing(0, 1, 0, 3, 0, 37, 1, 1);
                4: timing = make_timing(1, 1, 0, 1, 5, 12, 0, 1);
                5: timing = make_timing(0, 1, 0, 0, 2, 5, 1, 0);
                default: begin
                    n = $urandom_range(2, 48);
                    timing = make_timing($urandom_range(0, 6), $urandom_range(1, 4),
                                         $urandom_range(0, 6), n,
                                         ($urandom_range(3) == 0) ? $urandom_range(1, 2047)
                                                                  : $urandom_range(1, n),
                                         $urandom_range(1, 1023), $urandom_range(1),
                                         $urandom_range(1));
                end
            endcase
            drain();
            apply_settings(timing);
            if (p == 15) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = idle_choice();
                stall_pct = idle_choice();
            end
            n = (p < 6) ? 30 : 150;
            for (int k = 0; k < n; k++) begin
                send_event(random_event());
            end
        end
        drain();

        $display("Sent %0d transfer events under %0d register settings, %0d results compared.",
                 events_sent, settings_used, compared);
        $display("Results included %0d line transfers and %0d sync-line transfers.",
                 line_results, sync_results);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d results still pending.", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/stseq_pkg.sv
src/stseq_step.sv
src/scanline_transfer_sequencer_core.sv
tb/scanline_transfer_sequencer_checker.sv
tb/tb_scanline_transfer_sequencer_core.sv
